// ===== rtl/pcpfl_pkg.sv =====
// pcpfl_pkg: shared types and constants of the per-cpu page free list allocator
// no dependencies; imported by the top level
`default_nettype none

package pcpfl_pkg;

  // page geometry: pages are a power of two in size
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

  // empty list marker in heads and links
  localparam logic [15:0] LINK_NONE = 16'hFFFF;

  // request kinds
  localparam logic OP_FREE  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_PAGE  = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_REGION_START = 2'd0;
  localparam logic [1:0] CFG_REGION_STOP  = 2'd1;
  localparam logic [1:0] CFG_STEAL_BATCH  = 2'd2;

  // configuration reset values
  localparam logic [31:0] REGION_START_RST = 32'd0;
  localparam logic [31:0] REGION_STOP_RST  = 32'd134217728;
  localparam logic [15:0] STEAL_BATCH_RST  = 16'd64;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_ALLOC,
    S_POP,
    S_SCAN,
    S_MOVE
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/per_cpu_page_free_list_allocator.sv =====
// per_cpu_page_free_list_allocator: top level, request sequencer and list heads
// depends on pcpfl_pkg and pcpfl_ram (link table)
//
// Usage:
//   Requests come in on the s_axis channel: tuser is the kind (free or
//   allocate), tdata carries the cpu index and the physical address. Each
//   request gives exactly one result on the m_axis channel: tdata is the
//   allocated page address (zero otherwise), tuser the status.
//   Registers (region start, region stop, steal batch) are written through
//   the cfg port while no request is in flight.
// Sequence:
//   A free passes through S_FREE, an allocation from a non-empty own list
//   through S_ALLOC and S_POP; both are set by the read-modify-write of the
//   link table. An allocation on an empty own list steals first: S_SCAN
//   passes over the cpu indexes in order (its own included) and S_MOVE moves
//   each page, then S_ALLOC pops a page through S_POP, or reports no page
//   when none could be moved. One request is in work at a time.
// Reset:
//   All lists are empty, registers take their reset values; the link table
//   needs no clearing pass since only written links are ever read.
// Backpressure:
//   The result waits in an output register; the next request is taken in the
//   same cycle the result leaves, and intake stalls while it is not taken.
`default_nettype none

module per_cpu_page_free_list_allocator
  import pcpfl_pkg::*;
#(
  parameter int NUM_CPUS  = 8,
  parameter int NUM_PAGES = 32768
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // cpu[2:0], phys_addr[34:3], zero pad
  input  wire logic        s_axis_tuser,   // op[0]
  // result channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // page_addr[31:0]
  output logic      [1:0]  m_axis_tuser,   // status[1:0]
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int VW = $clog2(NUM_CPUS + 1);
  localparam int AW = $clog2(NUM_PAGES);
  localparam int IW = 33 - PAGE_SHIFT;
  localparam logic [15:0] NUM_PAGES_W = 16'(NUM_PAGES);
  localparam logic [VW-1:0] NUM_CPUS_W = VW'(NUM_CPUS);

  // fold a raw 3-bit cpu index into the cpu count by repeated subtraction
  function automatic logic [CW-1:0] cpu_fold(input logic [2:0] raw);
    logic [6:0] v;
    v = 7'(raw);
    for (int k = 0; k < 8; k++) begin
      if (v >= 7'(NUM_CPUS)) begin
        v = v - 7'(NUM_CPUS);
      end
    end
    return CW'(v);
  endfunction

  // configuration
  logic [31:0] start_q, stop_q;
  logic [15:0] batch_q;
  logic [32:0] base_q;

  // request and sequencer state
  state_e        state_q, state_d;
  logic          op_q, op_d;
  logic [CW-1:0] cpu_q, cpu_d;
  logic [31:0]   addr_q, addr_d;
  logic [15:0]   head_q [NUM_CPUS];
  logic [15:0]   own_q, own_d;
  logic [15:0]   pop_q, pop_d;
  logic [15:0]   left_q, left_d;
  logic [VW-1:0] vic_q, vic_d;
  logic          stolen_q, stolen_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_addr_q, out_addr_d;
  logic [1:0]  out_status_q, out_status_d;
  logic        out_load;

  // link table and head access
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic          head_we;
  logic [CW-1:0] head_widx, head_ridx;
  logic [15:0]   head_wdata, head_rd;
  logic          head_ok, head_none;

  logic in_acc;
  logic [CW-1:0] in_cpu;

  // free address check
  logic [32:0]   diff;
  logic [IW-1:0] free_idx;
  logic          free_bad;

  // steal scan control
  logic scan_done, scan_skip;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_cpu = cpu_fold(s_axis_tdata[2:0]);

  // one head read port, steered by the sequencer
  assign head_ridx = (state_q == S_SCAN) ? vic_q[CW-1:0] : cpu_q;
  assign head_rd   = head_q[head_ridx];
  assign head_none = (head_rd == LINK_NONE);
  assign head_ok   = (head_rd < NUM_PAGES_W);

  assign diff     = {1'b0, addr_q} - base_q;
  assign free_idx = diff[32:PAGE_SHIFT];
  assign free_bad = (addr_q[PAGE_SHIFT-1:0] != '0) || (addr_q < start_q) ||
                    (addr_q >= stop_q) || ({1'b0, addr_q} < base_q) ||
                    (free_idx >= IW'(NUM_PAGES));

  assign scan_done = (left_q == 16'd0) || (vic_q == NUM_CPUS_W);
  assign scan_skip = (vic_q == VW'(cpu_q)) || !head_ok;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tuser == OP_ALLOC) ? S_ALLOC : S_FREE;
        end
      end
      S_FREE: state_d = S_IDLE;
      S_ALLOC: begin
        if (head_none && !stolen_q) begin
          state_d = S_SCAN;
        end else if (head_ok) begin
          state_d = S_POP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_POP: state_d = S_IDLE;
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_ALLOC;
        end else if (!scan_skip) begin
          state_d = S_MOVE;
        end
      end
      S_MOVE: state_d = S_SCAN;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control per state
  always_comb begin
    op_d         = op_q;
    cpu_d        = cpu_q;
    addr_d       = addr_q;
    own_d        = own_q;
    pop_d        = pop_q;
    left_d       = left_q;
    vic_d        = vic_q;
    stolen_d     = stolen_q;
    out_load     = 1'b0;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = pop_q[AW-1:0];
    ram_wdata    = own_q;
    ram_re       = 1'b0;
    ram_raddr    = head_rd[AW-1:0];
    head_we      = 1'b0;
    head_widx    = cpu_q;
    head_wdata   = own_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d     = s_axis_tuser;
          cpu_d    = in_cpu;
          addr_d   = s_axis_tdata[34:3];
          stolen_d = 1'b0;
        end
      end
      S_FREE: begin
        // push onto the own list, or reject the address
        out_load   = 1'b1;
        out_addr_d = '0;
        if (free_bad) begin
          out_status_d = ST_BAD_ADDR;
        end else begin
          out_status_d = ST_DONE;
          ram_we       = 1'b1;
          ram_waddr    = free_idx[AW-1:0];
          ram_wdata    = head_rd;
          head_we      = 1'b1;
          head_wdata   = 16'(free_idx[AW-1:0]);
        end
      end
      S_ALLOC: begin
        if (head_none && !stolen_q) begin
          own_d    = LINK_NONE;
          vic_d    = '0;
          left_d   = batch_q;
          stolen_d = 1'b1;
        end else if (head_ok) begin
          ram_re = 1'b1;
          pop_d  = head_rd;
        end else begin
          out_load     = 1'b1;
          out_addr_d   = '0;
          out_status_d = ST_NO_PAGE;
        end
      end
      S_POP: begin
        // unlink the head and report its address
        head_we      = 1'b1;
        head_wdata   = ram_rdata;
        out_load     = 1'b1;
        out_addr_d   = base_q[31:0] + (32'(pop_q) << PAGE_SHIFT);
        out_status_d = ST_DONE;
      end
      S_SCAN: begin
        if (scan_done) begin
          head_we = 1'b1;
        end else if (scan_skip) begin
          vic_d = vic_q + VW'(1);
        end else begin
          ram_re = 1'b1;
          pop_d  = head_rd;
        end
      end
      S_MOVE: begin
        // victim head advances, page goes onto the collected list
        head_we    = 1'b1;
        head_widx  = vic_q[CW-1:0];
        head_wdata = ram_rdata;
        ram_we     = 1'b1;
        own_d      = pop_q;
        left_d     = left_q - 16'd1;
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  // control registers, heads and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      stolen_q    <= 1'b0;
      start_q     <= REGION_START_RST;
      stop_q      <= REGION_STOP_RST;
      batch_q     <= STEAL_BATCH_RST;
      base_q      <= {1'b0, REGION_START_RST};
      for (int i = 0; i < NUM_CPUS; i++) begin
        head_q[i] <= LINK_NONE;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      stolen_q    <= stolen_d;
      if (head_we) begin
        head_q[head_widx] <= head_wdata;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REGION_START: begin
            start_q <= cfg_data_i;
            base_q  <= ({1'b0, cfg_data_i} + 33'(PAGE_BYTES - 1)) &
                       ~33'(PAGE_BYTES - 1);
          end
          CFG_REGION_STOP: stop_q  <= cfg_data_i;
          CFG_STEAL_BATCH: batch_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    cpu_q        <= cpu_d;
    addr_q       <= addr_d;
    own_q        <= own_d;
    pop_q        <= pop_d;
    left_q       <= left_d;
    vic_q        <= vic_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  // link table
  pcpfl_ram #(
    .WIDTH(16),
    .DEPTH(NUM_PAGES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_status_q;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten");

  // stealing never reads the requesting cpu's own list
  a_no_self_steal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && ram_re) |-> (vic_q != VW'(cpu_q)))
    else $error("steal from own list");

  // every moved page uses up one unit of the batch
  a_batch_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |=> (left_q == $past(left_q) - 16'd1))
    else $error("steal batch count off");

  // only allocations visit the steal states
  a_steal_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_MOVE) |-> (op_q == OP_ALLOC && stolen_q))
    else $error("steal outside an allocation");

endmodule

`default_nettype wire

// ===== rtl/pcpfl_ram.sv =====
// pcpfl_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies
`default_nettype none

module pcpfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sim/per_cpu_page_free_list_allocator_tb.sv =====
// per_cpu_page_free_list_allocator_tb: self-checking bench for the per-cpu page allocator
// depends on pcpfl_pkg and the per_cpu_page_free_list_allocator rtl
// drives directed then random free/alloc requests; checks results by typed row or predictor

module per_cpu_page_free_list_allocator_tb;
  import pcpfl_pkg::*;

  localparam int NUM_CPUS  = 8;
  localparam int NUM_PAGES = 32768;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] page;
    logic [1:0]  status;
  } page_result_t;

  typedef struct packed {
    logic         op;
    logic [2:0]   cpu;
    logic [31:0]  addr;
    bit           typed;
    page_result_t result;
  } directed_row_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] stop;
    logic [15:0] batch;
    int          items;
  } region_setting_t;

  localparam page_result_t R_DONE    = '{page: 32'h0, status: ST_DONE};
  localparam page_result_t R_NO_PAGE = '{page: 32'h0, status: ST_NO_PAGE};
  localparam page_result_t R_BAD     = '{page: 32'h0, status: ST_BAD_ADDR};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // cpu[2:0], phys_addr[34:3], zero pad
  logic        s_axis_tuser;   // op[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // page_addr[31:0]
  logic [1:0]  m_axis_tuser;   // status[1:0]
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  // predictor copy of registers and free lists
  logic [31:0]  cfg_region_start;
  logic [31:0]  cfg_region_stop;
  logic [15:0]  cfg_steal_batch;
  logic [15:0]  free_head [NUM_CPUS];
  logic [15:0]  page_link [NUM_PAGES];
  byte unsigned list_refs [NUM_PAGES];

  page_result_t  expected_results [$];
  logic [31:0]   held_addrs [$];
  directed_row_t directed_rows [$];
  region_setting_t region_settings [$];

  bit tx_idles;
  bit rx_idles;
  bit hold_request;
  int error_count;

  per_cpu_page_free_list_allocator #(
    .NUM_CPUS (NUM_CPUS),
    .NUM_PAGES(NUM_PAGES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(64'd8 * 64'd3_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  // first page address: region start rounded up to a page boundary
  function automatic logic [32:0] page_base();
    return (({1'b0, cfg_region_start} + 33'(PAGE_BYTES - 1)) >> PAGE_SHIFT) << PAGE_SHIFT;
  endfunction

  // page index of a free address, returns 0 for a bad address
  function automatic bit page_index_of(input logic [31:0] addr, output logic [15:0] idx);
    logic [32:0] base;
    logic [32:0] offs;
    base = page_base();
    offs = ({1'b0, addr} - base) >> PAGE_SHIFT;
    idx  = offs[15:0];
    return addr[PAGE_SHIFT-1:0] == '0 && addr >= cfg_region_start && addr < cfg_region_stop
           && {1'b0, addr} >= base && offs < NUM_PAGES;
  endfunction

  function automatic void push_page(input int c, input logic [15:0] idx);
    page_link[idx] = free_head[c];
    free_head[c]   = idx;
    list_refs[idx]++;
  endfunction

  function automatic logic [15:0] pop_page(input int c);
    logic [15:0] h;
    h = free_head[c];
    if (h != LINK_NONE && h < NUM_PAGES) begin
      free_head[c] = page_link[h];
      list_refs[h]--;
    end else begin
      h = LINK_NONE;
    end
    return h;
  endfunction

  // allocator behavior for one request, updates the lists
  function automatic page_result_t predict_request(input logic op, input logic [2:0] cpu,
                                                   input logic [31:0] addr);
    logic [15:0]  idx;
    logic [15:0]  left;
    logic [15:0]  pg;
    logic [32:0]  addr_sum;
    page_result_t r;
    r = R_DONE;
    if (op == OP_FREE) begin
      if (page_index_of(addr, idx)) push_page(int'(cpu), idx);
      else r.status = ST_BAD_ADDR;
      return r;
    end
    // own list empty: steal from the other cpus in index order
    if (free_head[cpu] == LINK_NONE) begin
      left = cfg_steal_batch;
      for (int k = 0; k < NUM_CPUS && left != 0; k++) begin
        if (k == int'(cpu)) continue;
        while (left != 0 && free_head[k] != LINK_NONE) begin
          pg = pop_page(k);
          if (pg == LINK_NONE) break;
          push_page(int'(cpu), pg);
          left--;
        end
      end
    end
    pg = pop_page(int'(cpu));
    if (pg == LINK_NONE) begin
      r.status = ST_NO_PAGE;
    end else begin
      addr_sum = page_base() + (33'(pg) << PAGE_SHIFT);
      r.page   = addr_sum[31:0];
    end
    return r;
  endfunction

  // register write, also updates the predictor copy
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_REGION_START: cfg_region_start = data;
      CFG_REGION_STOP:  cfg_region_stop  = data;
      CFG_STEAL_BATCH:  cfg_steal_batch  = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one request transaction with optional idle burst before it
  task automatic issue_request(input logic op, input logic [2:0] cpu, input logic [31:0] addr,
                               input bit has_typed, input page_result_t typed_result);
    int gap;
    page_result_t predicted;
    gap = (tx_idles && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 14)) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, addr, cpu};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_request(op, cpu, addr);
    expected_results.push_back(has_typed ? typed_result : predicted);
    if (op == OP_ALLOC && predicted.status == ST_DONE) held_addrs.push_back(predicted.page);
  endtask

  // stop offering and let every outstanding result drain
  task automatic drain_requests();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  // result receiver: random stall bursts plus one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && hold_request) begin
        stall_left   = 300;
        hold_request = 1'b0;
      end else if (stall_left == 0 && rx_idles && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    page_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result: page %h status %0d", m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata !== want.page || m_axis_tuser !== want.status) begin
          if (error_count < 10)
            $display("mismatch: expected page %h status %0d, got page %h status %0d",
                     want.page, want.status, m_axis_tdata, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic        op;
    logic [2:0]  cpu;
    logic [31:0] addr;
    logic [32:0] base;
    logic [15:0] idx;
    longint unsigned span;
    int pick;
    int j;
    region_setting_t rs;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_FREE;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_REGION_START;
    cfg_data_i    = '0;
    tx_idles      = 1'b1;
    rx_idles      = 1'b1;
    hold_request  = 1'b0;
    error_count   = 0;
    cfg_region_start = REGION_START_RST;
    cfg_region_stop  = REGION_STOP_RST;
    cfg_steal_batch  = STEAL_BATCH_RST;
    for (int c = 0; c < NUM_CPUS; c++) free_head[c] = LINK_NONE;

    // directed requests under reset settings
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd0, 32'h0000_0000, 1'b1, R_NO_PAGE});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd0, 32'h0000_0001, 1'b1, R_BAD});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd0, 32'h0800_0000, 1'b1, R_BAD});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd0, 32'hFFFF_F000, 1'b1, R_BAD});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd0, 32'h0000_0800, 1'b1, R_BAD});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd7, 32'h07FF_F000, 1'b1, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd0, 32'h0000_0000, 1'b1, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd7, 32'hFFFF_FFFF, 1'b1,
                                            page_result_t'{32'h07FF_F000, ST_DONE}});
    // own list empty: one page stolen from cpu 0
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd7, 32'h0000_0000, 1'b1, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd3, 32'h0000_0000, 1'b1, R_NO_PAGE});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd1, 32'h0000_1000, 1'b1, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd2, 32'h0000_2000, 1'b1, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd2, 32'h0000_3000, 1'b1, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd5, 32'h0000_4000, 1'b1, R_DONE});
    // steal across several cpus
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd6, 32'h0000_0000, 1'b0, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd6, 32'h0000_0000, 1'b0, R_DONE});
    // double free of one page onto two lists
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd1, 32'h0000_A000, 1'b1, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd1, 32'h0000_B000, 1'b1, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_FREE,  3'd2, 32'h0000_A000, 1'b1, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd2, 32'h0000_0000, 1'b0, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd1, 32'h0000_0000, 1'b0, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd1, 32'h0000_0000, 1'b0, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd6, 32'h0000_0000, 1'b0, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd6, 32'h0000_0000, 1'b0, R_DONE});
    directed_rows.push_back(directed_row_t'{OP_ALLOC, 3'd4, 32'h0000_0000, 1'b1, R_NO_PAGE});

    // register settings of the random phases, extremes among them
    region_settings.push_back(region_setting_t'{32'h0000_0000, 32'h0800_0000, 16'd64, 200});
    region_settings.push_back(region_setting_t'{32'h1000_0123, 32'h1012_C123, 16'd1, 150});
    region_settings.push_back(region_setting_t'{32'h8000_0000, 32'hFFFF_FFFF, 16'd32768, 150});
    region_settings.push_back(region_setting_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 60});
    region_settings.push_back(region_setting_t'{32'h0000_0000, 32'h0000_0000, 16'd3, 50});
    region_settings.push_back(region_setting_t'{32'hFFFF_F000, 32'hFFFF_FFFF, 16'd2, 70});
    region_settings.push_back(region_setting_t'{32'h0040_0000, 32'h0048_0000, 16'd8, 250});

    // reset
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      issue_request(directed_rows[i].op, directed_rows[i].cpu, directed_rows[i].addr,
                    directed_rows[i].typed, directed_rows[i].result);
    // the double free left two copies of one page in the held set
    held_addrs.delete();

    foreach (region_settings[p]) begin
      rs = region_settings[p];
      drain_requests();
      write_reg(CFG_REGION_START, rs.start);
      write_reg(CFG_REGION_STOP,  rs.stop);
      write_reg(CFG_STEAL_BATCH,  {16'h0, rs.batch});
      if (p == 3) write_reg(CFG_UNUSED, $urandom());
      for (int n = 0; n < rs.items; n++) begin
        // idling mode changes now and then, none in the last phase
        if (n % 40 == 0) begin
          tx_idles = (p != region_settings.size() - 1) && $urandom_range(0, 3) != 0;
          rx_idles = (p != region_settings.size() - 1) && $urandom_range(0, 3) != 0;
        end
        if (p == 0 && n == 30) hold_request = 1'b1;

        base = page_base();
        span = (cfg_region_stop > base) ?
               (longint'(cfg_region_stop) - longint'(base) + PAGE_BYTES - 1) >> PAGE_SHIFT : 0;
        if (span > NUM_PAGES) span = NUM_PAGES;
        cpu  = $urandom_range(0, NUM_CPUS - 1);
        addr = $urandom();
        if ($urandom_range(0, 99) < 45) begin
          op = OP_ALLOC;
        end else begin
          op   = OP_FREE;
          pick = $urandom_range(0, 99);
          if (pick < 55 && held_addrs.size() > 0) begin
            j    = $urandom_range(0, held_addrs.size() - 1);
            addr = held_addrs[j];
            held_addrs.delete(j);
          end else if (pick < 80 && span > 0) begin
            addr = 32'(base + ($urandom_range(0, 32'(span - 1)) << PAGE_SHIFT));
          end else if (pick < 90) begin
            // region edges and near-miss alignment
            case ($urandom_range(0, 4))
              0: addr = cfg_region_start;
              1: addr = cfg_region_stop;
              2: addr = cfg_region_stop - PAGE_BYTES;
              3: addr = 32'(base) - PAGE_BYTES;
              default: addr = 32'(base) ^ (32'h1 << $urandom_range(0, PAGE_SHIFT - 1));
            endcase
          end
          // keep the lists acyclic: never list a page that is already listed
          if (page_index_of(addr, idx) && list_refs[idx] != 0) addr = addr | 32'h1;
        end
        issue_request(op, cpu, addr, 1'b0, R_DONE);
      end
    end

    // wait out the last results
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pcpfl_pkg.sv
rtl/pcpfl_ram.sv
rtl/per_cpu_page_free_list_allocator.sv
sim/per_cpu_page_free_list_allocator_tb.sv
